/* sv/epoch_seconds_to_calendar_defines.svh */
// Assertion macros for the epoch seconds to calendar converter.
// Included by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define ES2C_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define ES2C_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* sv/es2c_pkg.sv */
// Shared types, constants and calendar helpers for the epoch converter.
// Used by the controller, the datapath and the top level; no dependencies.
package es2c_pkg;

  localparam int unsigned InWidth  = 31;
  localparam int unsigned DaysW    = 15;

  localparam logic [10:0] EpochYear    = 11'd1970;
  localparam logic [2:0]  EpochWeekday = 3'd4;

  // Divisors of the shared divider.
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [16:0] SecsPerMin  = 17'd60;
  localparam logic [16:0] DaysPerWeek = 17'd7;

  // Reciprocals: quotient = ((n >> pre) * recip) >> post, exact over the
  // reachable numerators. Pre-shifts are 7, 4, 2 and 0 (the power-of-two
  // factor of each divisor); post-shifts follow below.
  localparam logic [24:0] RecipDay  = 25'd25451659;
  localparam logic [24:0] RecipHour = 25'd9321;
  localparam logic [24:0] RecipMin  = 25'd1093;
  localparam logic [24:0] RecipWeek = 25'd37450;

  localparam int unsigned DayPost  = 34;
  localparam int unsigned HourPost = 21;
  localparam int unsigned MinPost  = 14;
  localparam int unsigned WeekPost = 18;

  localparam logic [3:0] LastMonthIdx = 4'd11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY_Q,
    ST_DAY_R,
    ST_HOUR_Q,
    ST_HOUR_R,
    ST_MIN_Q,
    ST_MIN_R,
    ST_WDAY_Q,
    ST_WDAY_R,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WEEK
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             div_q;
    logic             div_r;
    div_sel_e         div_sel;
    logic             year_step;
    logic             save_doy;
    logic             month_step;
    logic             publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_more;
    logic month_more;
  } sts_t;

  // Leap rule for the years this block can reach (1970..2038): the only
  // century year in that span is 2000, which is a multiple of 400, so the
  // multiple-of-four test is exact.
  function automatic logic is_leap(input logic [10:0] year);
    return (year[1:0] == 2'b00);
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  // Month length, month index counted from zero.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd1:                       len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [16:0] divisor(input div_sel_e sel);
    logic [16:0] d;
    unique case (sel)
      DIV_DAY:  d = SecsPerDay;
      DIV_HOUR: d = SecsPerHour;
      DIV_MIN:  d = SecsPerMin;
      DIV_WEEK: d = DaysPerWeek;
      default:  d = SecsPerDay;
    endcase
    return d;
  endfunction

endpackage

/* sv/epoch_seconds_to_calendar.sv */
// Top level of the epoch seconds to calendar converter.
// Instantiates es2c_ctrl and es2c_dpath; uses es2c_pkg and the defines header.
//
//   Channel   Dir  Payload (tdata, low bit first)
//   s_axis    in   epoch_seconds[30:0], pad[31]
//   m_axis    out  second, minute, hour, day_of_month, month, year,
//                  day_of_year, week_day, pad[55:49]
//
// An item goes from its input transfer through the reciprocal divisions (quotient, then
// remainder, for day, hour, minute and weekday), then a year search and a month search
// that step once per whole year or month and once more to leave, then a load of the result.
// Reset clears the controller and the result flag. A stalled result waits in its own
// register; the next item is taken meanwhile and holds in its final state until then.
`include "epoch_seconds_to_calendar_defines.svh"

module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] epoch_seconds, [31] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                      // [21:17] day_of_month, [25:22] month,
                                      // [36:26] year, [45:37] day_of_year,
                                      // [48:46] week_day, [55:49] zero
);

  es2c_pkg::cmd_t cmd;
  es2c_pkg::sts_t sts;

  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day_of_month;
  logic [3:0]  month;
  logic [10:0] year;
  logic [8:0]  day_of_year;
  logic [2:0]  week_day;

  es2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  es2c_dpath u_dpath (
    .clk_i           (clk_i),
    .epoch_seconds_i (s_axis_tdata[es2c_pkg::InWidth-1:0]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .second_o        (second),
    .minute_o        (minute),
    .hour_o          (hour),
    .day_of_month_o  (day_of_month),
    .month_o         (month),
    .year_o          (year),
    .day_of_year_o   (day_of_year),
    .week_day_o      (week_day)
  );

  assign m_axis_tdata = {7'd0, week_day, day_of_year, year, month, day_of_month,
                         hour, minute, second};

  // Checks on the conversion sequence and the result fields.
  `ES2C_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "block still ready right after an input transfer")
  `ES2C_ASSERT_NOW(a_time_range, m_axis_tvalid, (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24), "time of day out of range")
  `ES2C_ASSERT_NOW(a_date_range, m_axis_tvalid, (month != 4'd0) && (month < 4'd13) && (day_of_month != 5'd0) && (week_day < 3'd7) && (day_of_year < 9'd366 || day_of_year == 9'd365), "calendar date out of range")

endmodule

/* sv/es2c_ctrl.sv */
// Sequencing controller of the epoch converter: state machine and the
// result valid flag. Depends on es2c_pkg.
module es2c_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  es2c_pkg::sts_t    sts_i,
  output es2c_pkg::cmd_t    cmd_o
);

  es2c_pkg::state_e               state_q, state_d;
  logic                           out_valid_q, out_valid_d;

  // State and result flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= es2c_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = es2c_pkg::DIV_DAY;
    unique case (state_q)
      es2c_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = es2c_pkg::ST_DAY_Q;
        end
      end
      es2c_pkg::ST_DAY_Q: begin
        cmd_o.div_q   = 1'b1;
        cmd_o.div_sel = es2c_pkg::DIV_DAY;
        state_d       = es2c_pkg::ST_DAY_R;
      end
      es2c_pkg::ST_DAY_R: begin
        cmd_o.div_r   = 1'b1;
        cmd_o.div_sel = es2c_pkg::DIV_DAY;
        state_d       = es2c_pkg::ST_HOUR_Q;
      end
      es2c_pkg::ST_HOUR_Q: begin
        cmd_o.div_q   = 1'b1;
        cmd_o.div_sel = es2c_pkg::DIV_HOUR;
        state_d       = es2c_pkg::ST_HOUR_R;
      end
      es2c_pkg::ST_HOUR_R: begin
        cmd_o.div_r   = 1'b1;
        cmd_o.div_sel = es2c_pkg::DIV_HOUR;
        state_d       = es2c_pkg::ST_MIN_Q;
      end
      es2c_pkg::ST_MIN_Q: begin
        cmd_o.div_q   = 1'b1;
        cmd_o.div_sel = es2c_pkg::DIV_MIN;
        state_d       = es2c_pkg::ST_MIN_R;
      end
      es2c_pkg::ST_MIN_R: begin
        cmd_o.div_r   = 1'b1;
        cmd_o.div_sel = es2c_pkg::DIV_MIN;
        state_d       = es2c_pkg::ST_WDAY_Q;
      end
      es2c_pkg::ST_WDAY_Q: begin
        cmd_o.div_q   = 1'b1;
        cmd_o.div_sel = es2c_pkg::DIV_WEEK;
        state_d       = es2c_pkg::ST_WDAY_R;
      end
      es2c_pkg::ST_WDAY_R: begin
        cmd_o.div_r   = 1'b1;
        cmd_o.div_sel = es2c_pkg::DIV_WEEK;
        state_d       = es2c_pkg::ST_YEAR;
      end
      es2c_pkg::ST_YEAR: begin
        if (sts_i.year_more) begin
          cmd_o.year_step = 1'b1;
        end else begin
          cmd_o.save_doy = 1'b1;
          state_d        = es2c_pkg::ST_MONTH;
        end
      end
      es2c_pkg::ST_MONTH: begin
        if (sts_i.month_more) begin
          cmd_o.month_step = 1'b1;
        end else begin
          state_d = es2c_pkg::ST_DONE;
        end
      end
      es2c_pkg::ST_DONE: begin
        // Load the result register once the previous result has gone.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = es2c_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = es2c_pkg::ST_IDLE;
      end
    endcase
  end

  // Result flag: set on publish, cleared when the transfer completes.
  always_comb begin
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_ready_o  = (state_q == es2c_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* sv/es2c_dpath.sv */
// Datapath of the epoch converter: shared reciprocal divider, year and month
// subtraction counters and the result register. Depends on es2c_pkg.
module es2c_dpath (
  input  logic                           clk_i,
  input  logic [es2c_pkg::InWidth-1:0]   epoch_seconds_i,
  input  es2c_pkg::cmd_t                 cmd_i,
  output es2c_pkg::sts_t                 sts_o,
  output logic [5:0]                     second_o,
  output logic [5:0]                     minute_o,
  output logic [4:0]                     hour_o,
  output logic [4:0]                     day_of_month_o,
  output logic [3:0]                     month_o,
  output logic [10:0]                    year_o,
  output logic [8:0]                     day_of_year_o,
  output logic [2:0]                     week_day_o
);

  logic [es2c_pkg::InWidth-1:0]  rem_q;
  logic [es2c_pkg::DaysW-1:0]    quo_q;
  logic [es2c_pkg::DaysW-1:0]    days_q;
  logic [4:0]                    hour_q;
  logic [5:0]                    min_q;
  logic [5:0]                    sec_q;
  logic [2:0]                    wday_q;
  logic [10:0]                   year_q;
  logic [3:0]                    mon_q;
  logic [8:0]                    doy_q;

  logic [23:0]                   mul_a;
  logic [24:0]                   mul_b;
  logic [48:0]                   prod;
  logic [es2c_pkg::DaysW-1:0]    quo_d;
  logic [31:0]                   back_prod;
  logic [es2c_pkg::InWidth-1:0]  rem_d;
  logic                          leap;
  logic [8:0]                    ylen;
  logic [4:0]                    mlen;

  // Quotient by reciprocal: scale the pre-shifted numerator and keep the
  // high product bits.
  always_comb begin
    unique case (cmd_i.div_sel)
      es2c_pkg::DIV_DAY: begin
        mul_a = rem_q[30:7];
        mul_b = es2c_pkg::RecipDay;
      end
      es2c_pkg::DIV_HOUR: begin
        mul_a = 24'(rem_q[16:4]);
        mul_b = es2c_pkg::RecipHour;
      end
      es2c_pkg::DIV_MIN: begin
        mul_a = 24'(rem_q[11:2]);
        mul_b = es2c_pkg::RecipMin;
      end
      es2c_pkg::DIV_WEEK: begin
        mul_a = 24'(rem_q[14:0]);
        mul_b = es2c_pkg::RecipWeek;
      end
      default: begin
        mul_a = rem_q[30:7];
        mul_b = es2c_pkg::RecipDay;
      end
    endcase
    prod = 49'(mul_a) * 49'(mul_b);
    unique case (cmd_i.div_sel)
      es2c_pkg::DIV_DAY:  quo_d = prod[es2c_pkg::DayPost +: 15];
      es2c_pkg::DIV_HOUR: quo_d = 15'(prod[es2c_pkg::HourPost +: 6]);
      es2c_pkg::DIV_MIN:  quo_d = 15'(prod[es2c_pkg::MinPost +: 7]);
      es2c_pkg::DIV_WEEK: quo_d = 15'(prod[es2c_pkg::WeekPost +: 13]);
      default:            quo_d = prod[es2c_pkg::DayPost +: 15];
    endcase
  end

  // Remainder: numerator less the registered quotient times the divisor.
  assign back_prod = 32'(quo_q) * 32'(es2c_pkg::divisor(cmd_i.div_sel));
  assign rem_d     = rem_q - back_prod[es2c_pkg::InWidth-1:0];

  // Year and month lengths for the current search position.
  assign leap = es2c_pkg::is_leap(year_q);
  assign ylen = es2c_pkg::year_len(leap);
  assign mlen = es2c_pkg::month_len(leap, mon_q);

  assign sts_o.year_more  = (days_q >= es2c_pkg::DaysW'(ylen));
  assign sts_o.month_more = (mon_q != es2c_pkg::LastMonthIdx) &&
                            (days_q >= es2c_pkg::DaysW'(mlen));

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q  <= epoch_seconds_i;
      year_q <= es2c_pkg::EpochYear;
      mon_q  <= '0;
    end
    if (cmd_i.div_q) begin
      quo_q <= quo_d;
    end
    if (cmd_i.div_r) begin
      // For day and hour, the remainder feeds the next pass and the quotient goes to its field.
      unique case (cmd_i.div_sel)
        es2c_pkg::DIV_DAY: begin
          days_q <= quo_q;
          rem_q  <= rem_d;
        end
        es2c_pkg::DIV_HOUR: begin
          hour_q <= quo_q[4:0];
          rem_q  <= rem_d;
        end
        es2c_pkg::DIV_MIN: begin
          // Seconds are what the minute pass leaves; the weekday pass then
          // reduces the day count offset by the epoch weekday.
          min_q <= quo_q[5:0];
          sec_q <= rem_d[5:0];
          rem_q <= es2c_pkg::InWidth'(days_q) + es2c_pkg::InWidth'(es2c_pkg::EpochWeekday);
        end
        es2c_pkg::DIV_WEEK: begin
          wday_q <= rem_d[2:0];
        end
        default: ;
      endcase
    end
    if (cmd_i.year_step) begin
      days_q <= days_q - es2c_pkg::DaysW'(ylen);
      year_q <= year_q + 11'd1;
    end
    if (cmd_i.save_doy) begin
      doy_q <= days_q[8:0];
    end
    if (cmd_i.month_step) begin
      days_q <= days_q - es2c_pkg::DaysW'(mlen);
      mon_q  <= mon_q + 4'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      second_o       <= sec_q;
      minute_o       <= min_q;
      hour_o         <= hour_q;
      day_of_month_o <= days_q[4:0] + 5'd1;
      month_o        <= mon_q + 4'd1;
      year_o         <= year_q;
      day_of_year_o  <= doy_q;
      week_day_o     <= wday_q;
    end
  end

endmodule

/* test/epoch_calendar_checker.sv */
// Checker for the epoch seconds to calendar converter: watches both stream channels,
// predicts every calendar date from the accepted seconds count and compares the results.
// Stand-alone; needs only the clock, the reset and the channel signals of the block.
module epoch_calendar_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] epoch_seconds, [31] zero
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // second, minute, hour, day_of_month, month,
                                      // year, day_of_year, week_day, zero
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned FirstYear   = 1970;
  localparam int unsigned FirstWeekday = 4;  // 1970-01-01 was a Thursday
  localparam int unsigned LastMonth   = 11;

  // Result layout; the last member sits in the lowest bits, as on m_axis_tdata.
  typedef struct packed {
    logic [2:0]  week_day;
    logic [8:0]  day_of_year;
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  calendar_t pending_dates[$];
  int        mismatch_count = 0;

  function automatic bit gregorian_leap(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Length of a month, counted from zero.
  function automatic int unsigned days_in_month(input bit leap, input int unsigned mon);
    case (mon)
      1:           return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  // Broken-down UTC date of a seconds count; only the low 31 bits count.
  function automatic calendar_t to_calendar_date(input logic [31:0] word);
    int unsigned secs;
    int unsigned whole_days;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned span;
    calendar_t   date;
    secs       = {1'b0, word[30:0]};
    whole_days = secs / SecsPerDay;
    days       = whole_days;
    yr         = FirstYear;
    mon        = 0;

    // Strip whole years, then whole months of the year found.
    span = gregorian_leap(yr) ? 366 : 365;
    while (days >= span) begin
      days -= span;
      yr++;
      span = gregorian_leap(yr) ? 366 : 365;
    end
    date.day_of_year = 9'(days);
    span = days_in_month(gregorian_leap(yr), mon);
    while (mon < LastMonth && days >= span) begin
      days -= span;
      mon++;
      span = days_in_month(gregorian_leap(yr), mon);
    end

    date.second       = 6'(secs % 60);
    date.minute       = 6'((secs / SecsPerMin) % 60);
    date.hour         = 5'((secs / SecsPerHour) % 24);
    date.day_of_month = 5'(days + 1);
    date.month        = 4'(mon + 1);
    date.year         = 11'(yr);
    date.week_day     = 3'((FirstWeekday + whole_days) % 7);
    return date;
  endfunction

  function automatic int field_mismatch(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", field, want, got);
    return 1;
  endfunction

  // Check each result transfer against the oldest prediction, then queue new predictions.
  always @(posedge clk_i) begin
    calendar_t got;
    calendar_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[48:0];
        if (pending_dates.size() == 0) begin
          $error("result transfer with no conversion outstanding: tdata=%h", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = pending_dates.pop_front();
          mismatch_count += field_mismatch("second", want.second, got.second)
                          + field_mismatch("minute", want.minute, got.minute)
                          + field_mismatch("hour", want.hour, got.hour)
                          + field_mismatch("day_of_month", want.day_of_month, got.day_of_month)
                          + field_mismatch("month", want.month, got.month)
                          + field_mismatch("year", want.year, got.year)
                          + field_mismatch("day_of_year", want.day_of_year, got.day_of_year)
                          + field_mismatch("week_day", want.week_day, got.week_day);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_dates.push_back(to_calendar_date(s_axis_tdata));
      end
      fail_count_o <= mismatch_count;
      pending_o    <= pending_dates.size();
    end
  end

endmodule

/* test/epoch_seconds_to_calendar_test.sv */
// Top of the testbench for the epoch seconds to calendar converter: clock, reset,
// seconds stimulus, result back-pressure and the verdict.
// Depends on epoch_seconds_to_calendar and on epoch_calendar_checker.
module epoch_seconds_to_calendar_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned SettleTicks = 130;      // worst conversion latency plus margin
  localparam int unsigned PhaseItems  = 300;
  localparam int unsigned SecsPerDay  = 86400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [30:0] epoch_seconds, [31] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;         // second, minute, hour, day_of_month, month,
                                     // year, day_of_year, week_day, zero

  int          fail_count;
  int          pending;
  int unsigned send_idle = 7;        // percent of cycles the sender holds back
  int unsigned recv_idle = 46;       // percent of cycles the receiver stalls
  int unsigned cycle_count = 0;

  epoch_seconds_to_calendar dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  epoch_calendar_checker u_calendar_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Random back-pressure on the result channel.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic bit gregorian_leap(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Zero-based day of year on which a month starts.
  function automatic int unsigned month_first_day(input bit leap, input int unsigned mon);
    int unsigned first;
    case (mon)
      0:       first = 0;
      1:       first = 31;
      2:       first = 59;
      3:       first = 90;
      4:       first = 120;
      5:       first = 151;
      6:       first = 181;
      7:       first = 212;
      8:       first = 243;
      9:       first = 273;
      10:      first = 304;
      default: first = 334;
    endcase
    return (leap && mon >= 2) ? first + 1 : first;
  endfunction

  // Seconds count of a given year, day of year and second of day.
  function automatic logic [31:0] epoch_at(input int unsigned yr, input int unsigned doy,
                                           input int unsigned sod);
    int unsigned days;
    days = doy;
    for (int unsigned y = 1970; y < yr; y++) days += gregorian_leap(y) ? 366 : 365;
    return 32'(days * SecsPerDay + sod);
  endfunction

  // Random seconds count: uniform, near month and year starts, around leap days, near zero or near the top.
  function automatic logic [31:0] random_seconds();
    int unsigned pick;
    int unsigned yr;
    int unsigned mon;
    logic [31:0] base;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return {1'b0, 31'($urandom())};
    end else if (pick < 70) begin
      yr   = $urandom_range(2037, 1970);
      mon  = $urandom_range(11, 0);
      base = epoch_at(yr, month_first_day(gregorian_leap(yr), mon), 0);
      case ($urandom_range(3))
        0:       return base;
        1:       return (base == 0) ? base : base - 1;
        2:       return base + SecsPerDay - 1;
        default: return base + $urandom_range(SecsPerDay - 1);
      endcase
    end else if (pick < 85) begin
      yr = 1972 + 4 * $urandom_range(16);
      return epoch_at(yr, $urandom_range(60, 58), $urandom_range(SecsPerDay - 1));
    end else if (pick < 93) begin
      return 32'($urandom_range(200000));
    end else begin
      return 32'h7FFF_FFFF - $urandom_range(100_000_000);
    end
  endfunction

  // Offer one seconds count and hold it until the transfer happens.
  task automatic send_seconds(input logic [31:0] word);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] corner_words[$];

    // Field extremes, time-of-day rollovers, year and leap-day edges, and
    // the pad bit above the seconds field, which must be ignored.
    corner_words = {32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                    32'd259200, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h2AAA_AAAA,
                    32'h5555_5555, 32'hFFFF_FFFF, 32'h8000_0000};
    corner_words.push_back(epoch_at(1970, 364, SecsPerDay - 1));
    corner_words.push_back(epoch_at(1971, 0, 0));
    corner_words.push_back(epoch_at(1972, 59, 0) - 1);
    corner_words.push_back(epoch_at(1972, 59, 0));
    corner_words.push_back(epoch_at(1972, 365, SecsPerDay - 1));
    corner_words.push_back(epoch_at(1999, 364, SecsPerDay - 1));
    corner_words.push_back(epoch_at(2000, 59, 43200));
    corner_words.push_back(epoch_at(2037, 364, SecsPerDay - 1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_words[i]) send_seconds(corner_words[i]);

    // Three load phases: slow receiver, slow sender, then no idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 7;
          recv_idle = 46;
        end
        1: begin
          send_idle = 46;
          recv_idle = 7;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (PhaseItems - (phase == 0 ? corner_words.size() : 0)) begin
        send_seconds(random_seconds());
      end
      drain_results();
    end

    repeat (SettleTicks) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/es2c_pkg.sv
sv/es2c_ctrl.sv
sv/es2c_dpath.sv
sv/epoch_seconds_to_calendar.sv
test/epoch_calendar_checker.sv
test/epoch_seconds_to_calendar_test.sv
